[rtl/core/fxalu_pkg.sv]
// shared types and codes for the fixed-point alu
package fxalu_pkg;
    typedef enum logic [3:0] {
        CMD_ADD   = 4'd0,
        CMD_SUBW  = 4'd1,
        CMD_MUL   = 4'd2,
        CMD_DIV   = 4'd3,
        CMD_INC   = 4'd4,
        CMD_DEC   = 4'd5,
        CMD_CMP   = 4'd6,
        CMD_MIN   = 4'd7,
        CMD_MAX   = 4'd8,
        CMD_FROMW = 4'd9,
        CMD_TOW   = 4'd10
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_OVF  = 2'd1,
        ST_DIV0 = 2'd2
    } status_t;

    localparam int WHOLE_BITS = 24;
    localparam int CMD_BITS   = 4;
    localparam int OUT_BITS   = 32;
endpackage

[rtl/core/fxalu_div.sv]
// pipelined restoring divider, one quotient bit per stage, with rounding
module fxalu_div #(
    parameter int NUM_BITS = 40,
    parameter int DEN_BITS = 32
) (
    input  logic                aclk,
    input  logic                en,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    output logic [NUM_BITS:0]   quo
);
    localparam int RW = DEN_BITS + 1;

    logic [NUM_BITS-1:0] q_reg   [NUM_BITS+1];
    logic [NUM_BITS-1:0] n_reg   [NUM_BITS+1];
    logic [RW-1:0]       r_reg   [NUM_BITS+1];
    logic [DEN_BITS-1:0] d_reg   [NUM_BITS+1];
    logic [NUM_BITS:0]   quo_reg;

    always_comb begin
        q_reg[0] = '0;
        n_reg[0] = num;
        r_reg[0] = '0;
        d_reg[0] = den;
    end

    for (genvar i = 0; i < NUM_BITS; i++) begin : g_stage
        logic [RW:0] sh;
        logic [RW:0] diff;
        assign sh   = {r_reg[i], n_reg[i][NUM_BITS-1]};
        assign diff = sh - {2'b0, d_reg[i]};
        always_ff @(posedge aclk) begin
            if (en) begin
                n_reg[i+1] <= n_reg[i] << 1;
                d_reg[i+1] <= d_reg[i];
                if (!diff[RW]) begin
                    r_reg[i+1] <= diff[RW-1:0];
                    q_reg[i+1] <= {q_reg[i][NUM_BITS-2:0], 1'b1};
                end else begin
                    r_reg[i+1] <= sh[RW-1:0];
                    q_reg[i+1] <= {q_reg[i][NUM_BITS-2:0], 1'b0};
                end
            end
        end
    end

    // round half away from zero: bump when 2*rem >= den
    logic [RW:0] rem2;
    assign rem2 = {r_reg[NUM_BITS], 1'b0};
    always_ff @(posedge aclk) begin
        if (en) begin
            quo_reg <= {1'b0, q_reg[NUM_BITS]}
                     + {{NUM_BITS{1'b0}}, (rem2 >= {2'b0, d_reg[NUM_BITS]})};
        end
    end
    assign quo = quo_reg;
endmodule

[rtl/core/fixed_point_q24_8_alu_unit.sv]
// top level of the signed q24.8 fixed-point alu
//
// channel | dir | request contents
// s_      | in  | tdata: cmd, operand_a, operand_b, whole_value
// m_      | out | tdata: result_value, is_less, is_equal, is_greater, status
//
// the pipeline depth is set by the divider,
// which resolves one quotient bit per stage; every operation takes that path
// one request in and one out per cycle when m_axis_tready is high
// aresetn clears only the valid bits; payload registers are not reset
// a stall on the result side freezes the whole pipeline in place
module fixed_point_q24_8_alu_unit #(
    parameter int FRAC_BITS = 8,
    parameter int WORD_BITS = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[3:0], operand_a[35:4], operand_b[67:36], whole_value[91:68]
    input  logic [95:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // result_value[31:0], is_less[32], is_equal[33], is_greater[34], status[36:35]
    output logic [39:0] m_axis_tdata
);
    localparam int W   = WORD_BITS;
    localparam int NB  = W + FRAC_BITS;
    localparam int WB  = fxalu_pkg::WHOLE_BITS;
    localparam int LAT = NB + 3;
    localparam int PW  = 2 * W;

    // input unpack
    logic [3:0]          cmd_in;
    logic signed [31:0]  a_raw, b_raw;
    logic signed [WB-1:0] w_in;
    logic signed [W-1:0] a_in, b_in;
    assign cmd_in = s_axis_tdata[3:0];
    assign a_raw  = s_axis_tdata[35:4];
    assign b_raw  = s_axis_tdata[67:36];
    assign w_in   = s_axis_tdata[91:68];
    assign a_in   = a_raw[W-1:0];
    assign b_in   = b_raw[W-1:0];

    logic en;
    logic [LAT-1:0] vld_reg;
    assign en            = m_axis_tready || !vld_reg[LAT-1];
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
        end
    end

    localparam logic signed [W+1:0] WMAX = (W+2)'((65'sd1 <<< (W-1)) - 1);
    localparam logic signed [W+1:0] WMIN = -WMAX - 1;

    // stage 1: magnitudes, simple operations, latched operands
    logic [3:0]          cmd1_reg;
    logic signed [W-1:0] simp1_reg;
    logic [1:0]          st1_reg;
    logic [2:0]          flg1_reg;
    logic [W-1:0]        ma1_reg, mb1_reg;
    logic                neg1_reg;
    logic [W-1:0]        simp_next;
    logic [1:0]          st_next;
    logic [2:0]          flg_next;
    logic signed [W+WB+1:0] ext;

    function automatic logic [W-1:0] satw(input logic signed [W+WB+1:0] v,
                                          output logic ovf);
        logic signed [W+WB+1:0] mx, mn;
        begin
            mx = (W+WB+2)'(WMAX);
            mn = (W+WB+2)'(WMIN);
            ovf = 1'b0;
            satw = v[W-1:0];
            if (v > mx) begin
                ovf = 1'b1; satw = mx[W-1:0];
            end else if (v < mn) begin
                ovf = 1'b1; satw = mn[W-1:0];
            end
        end
    endfunction

    always_comb begin
        logic o;
        logic signed [W+WB+1:0] wsh;
        simp_next = '0;
        st_next   = fxalu_pkg::ST_OK;
        flg_next  = '0;
        o         = 1'b0;
        wsh       = (W+WB+2)'(w_in) <<< FRAC_BITS;
        ext       = '0;
        case (cmd_in)
            fxalu_pkg::CMD_ADD: simp_next = a_in + b_in;
            fxalu_pkg::CMD_SUBW: begin
                ext = (W+WB+2)'(a_in) - wsh;
                simp_next = satw(ext, o);
            end
            fxalu_pkg::CMD_INC: begin
                ext = (W+WB+2)'(a_in) + 1;
                simp_next = satw(ext, o);
            end
            fxalu_pkg::CMD_DEC: begin
                ext = (W+WB+2)'(a_in) - 1;
                simp_next = satw(ext, o);
            end
            fxalu_pkg::CMD_CMP:
                flg_next = {a_in > b_in, a_in == b_in, a_in < b_in};
            fxalu_pkg::CMD_MIN: simp_next = (a_in < b_in) ? a_in : b_in;
            fxalu_pkg::CMD_MAX: simp_next = (a_in > b_in) ? a_in : b_in;
            fxalu_pkg::CMD_FROMW: simp_next = satw(wsh, o);
            fxalu_pkg::CMD_TOW: simp_next = a_in >>> FRAC_BITS;
            default: simp_next = '0;
        endcase
        if (o) st_next = fxalu_pkg::ST_OVF;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cmd1_reg  <= cmd_in;
            simp1_reg <= simp_next;
            st1_reg   <= st_next;
            flg1_reg  <= flg_next;
            ma1_reg   <= a_in[W-1] ? -a_in : a_in;
            mb1_reg   <= b_in[W-1] ? -b_in : b_in;
            neg1_reg  <= a_in[W-1] ^ b_in[W-1];
        end
    end

    // side pipeline carrying per-request data alongside the divider
    localparam int DL = NB + 1;
    logic [3:0]          cmd_d  [DL];
    logic [W-1:0]        simp_d [DL];
    logic [1:0]          st_d   [DL];
    logic [2:0]          flg_d  [DL];
    logic                neg_d  [DL];
    logic                bz_d   [DL];
    logic [PW-1:0]       prod_d [DL];
    logic [PW-1:0]       prod2_reg;

    // multiply in stage 2, keep product through the side pipe
    always_ff @(posedge aclk) begin
        if (en) begin
            prod2_reg <= PW'(ma1_reg) * PW'(mb1_reg);
            cmd_d[0]  <= cmd1_reg;
            simp_d[0] <= simp1_reg;
            st_d[0]   <= st1_reg;
            flg_d[0]  <= flg1_reg;
            neg_d[0]  <= neg1_reg;
            bz_d[0]   <= (mb1_reg == '0);
        end
    end
    assign prod_d[0] = prod2_reg;

    for (genvar k = 1; k < DL; k++) begin : g_side
        logic [PW-1:0] p_reg;
        always_ff @(posedge aclk) begin
            if (en) begin
                cmd_d[k]  <= cmd_d[k-1];
                simp_d[k] <= simp_d[k-1];
                st_d[k]   <= st_d[k-1];
                flg_d[k]  <= flg_d[k-1];
                neg_d[k]  <= neg_d[k-1];
                bz_d[k]   <= bz_d[k-1];
                p_reg     <= prod_d[k-1];
            end
        end
        assign prod_d[k] = p_reg;
    end

    logic [NB:0] quo;
    fxalu_div #(.NUM_BITS(NB), .DEN_BITS(W)) u_div (
        .aclk (aclk),
        .en   (en),
        .num  ({ma1_reg, {FRAC_BITS{1'b0}}}),
        .den  (mb1_reg),
        .quo  (quo)
    );

    // final stage: round product, sign and saturate mul/div, flag divide by zero, select
    localparam int MX = PW + 2;
    logic [PW:0]          mq;
    logic [MX-1:0]        mag_sel;
    logic signed [MX:0]   sv;
    logic [W-1:0]         res_next;
    logic [1:0]           stf_next;
    logic [2:0]           flf_next;
    logic [W-1:0]         res_reg;
    logic [1:0]           stf_reg;
    logic [2:0]           flf_reg;

    always_comb begin
        logic [3:0] c;
        c  = cmd_d[DL-1];
        mq = ({1'b0, prod_d[DL-1]} + (PW+1)'(1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        mag_sel  = (c == fxalu_pkg::CMD_MUL) ? MX'(mq) : MX'(quo);
        sv       = neg_d[DL-1] ? -$signed({1'b0, mag_sel}) : $signed({1'b0, mag_sel});
        res_next = simp_d[DL-1];
        stf_next = st_d[DL-1];
        flf_next = flg_d[DL-1];
        if (c == fxalu_pkg::CMD_MUL || c == fxalu_pkg::CMD_DIV) begin
            stf_next = fxalu_pkg::ST_OK;
            if (c == fxalu_pkg::CMD_DIV && bz_d[DL-1]) begin
                res_next = '0;
                stf_next = fxalu_pkg::ST_DIV0;
            end else if (sv > (MX+1)'(WMAX)) begin
                res_next = WMAX[W-1:0];
                stf_next = fxalu_pkg::ST_OVF;
            end else if (sv < (MX+1)'(WMIN)) begin
                res_next = WMIN[W-1:0];
                stf_next = fxalu_pkg::ST_OVF;
            end else begin
                res_next = sv[W-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            res_reg <= res_next;
            stf_reg <= stf_next;
            flf_reg <= flf_next;
        end
    end

    logic signed [31:0] res_out;
    assign res_out      = 32'($signed(res_reg));
    assign m_axis_tdata = {3'b0, stf_reg, flf_reg, res_out};
endmodule
